### rtl/core/pfa_pkg.sv
// Shared types, codes and helpers for the page frame allocator.
`default_nettype none

package pfa_pkg;

  localparam int unsigned NUM_FRAMES_DEF  = 262144;
  localparam int unsigned FRAME_BYTES_DEF = 4096;

  localparam int unsigned RES_W  = 19;
  localparam int unsigned ADDR_W = 30;

  localparam logic [RES_W-1:0] RESERVED_RESET = 19'd2113;

  // request kinds
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] frame_address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_AL_SUM,
    S_AL_MAP,
    S_FR_MAP
  } state_t;

  // index of the lowest clear bit; meaningful only when one is clear
  function automatic logic [5:0] first_zero64(input logic [63:0] w);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (!w[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pfa_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module pfa_ram #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/page_frame_allocator_core.sv
// Top level: bitmap first-fit page frame allocator with a two-level full-word summary.
//
//  channel   | signals                     | transfer when
//  ----------+-----------------------------+-------------------------
//  request   | start, busy, request        | start && !busy
//  result    | done, result                | done (one cycle, no stall)
//  config    | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// Allocate: summary row read, map word read, write back; free: map and summary read,
// then write back; full, out-of-range and unused requests finish at acceptance;
// initialize: sweep of all MAP_WORDS map words, one map word written per cycle.
// Result strobes the cycle after; the steps follow from the registered map and summary reads.
// After reset the map is rebuilt by the same sweep as initialize; busy stays high.
// Results cannot be stalled; cfg_ready is always high.
`default_nettype none

module page_frame_allocator_core #(
  parameter int unsigned NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
  parameter int unsigned FRAME_BYTES = pfa_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire pfa_pkg::request_t        request,
  output logic                          done,
  output pfa_pkg::result_t              result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [pfa_pkg::RES_W-1:0] cfg_data
);

  localparam int unsigned MAP_WORDS  = (NUM_FRAMES + 63) / 64;
  localparam int unsigned SUM_ROWS   = (MAP_WORDS + 63) / 64;
  localparam int unsigned MW_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned RW_AW      = (SUM_ROWS > 1) ? $clog2(SUM_ROWS) : 1;
  localparam int unsigned WIDX_W     = RW_AW + 6;
  localparam int unsigned FI_W       = WIDX_W + 6;
  localparam int unsigned PAGE_SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int unsigned LAST_BITS  = NUM_FRAMES % 64;
  localparam logic [63:0] LAST_PAD   =
    (LAST_BITS == 0) ? 64'd0 : ~((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [31:0] RST_CNT32  =
    (32'(pfa_pkg::RESERVED_RESET) > 32'(NUM_FRAMES)) ? 32'(NUM_FRAMES)
                                                     : 32'(pfa_pkg::RESERVED_RESET);

  pfa_pkg::state_t state, state_next;

  logic [pfa_pkg::RES_W-1:0] reserved_pages;
  logic [CNT_W-1:0]          init_count;
  logic                      init_report;
  logic [WIDX_W-1:0]         sweep;
  logic [63:0]               sum_acc;
  logic [SUM_ROWS-1:0]       top_full;
  logic [RW_AW-1:0]          row;
  logic [WIDX_W-1:0]         word_idx;
  logic [63:0]               sum_row;
  logic [5:0]                fr_bit;

  // RAM ports
  logic              map_we;
  logic [MW_AW-1:0]  map_waddr, map_raddr;
  logic [63:0]       map_wdata, map_rdata;
  logic              sum_we;
  logic [RW_AW-1:0]  sum_waddr, sum_raddr;
  logic [63:0]       sum_wdata, sum_rdata;

  logic              top_we;
  logic [RW_AW-1:0]  top_idx;
  logic              top_val;
  logic              fin;
  pfa_pkg::result_t  fin_result;

  logic              accept;
  logic [31:0]       res32, sat32;
  logic [31:0]       fidx;
  logic              f_range;
  logic [WIDX_W-1:0] f_word;
  logic [5:0]        f_bit;
  logic              top_free;
  logic [RW_AW-1:0]  top_row;

  logic [CNT_W-1:0]  full_words;
  logic [63:0]       low_mask, s_val, s_acc, s_row_val;
  logic              s_last, s_row_wr;

  logic [5:0]        sb, mb;
  logic [WIDX_W-1:0] al_word;
  logic [63:0]       new_word, new_sum;
  logic [FI_W-1:0]   frame;
  logic [31:0]       grant32;

  pfa_ram #(.W(64), .DEPTH(MAP_WORDS), .AW(MW_AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  pfa_ram #(.W(64), .DEPTH(SUM_ROWS), .AW(RW_AW)) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign busy      = (state != pfa_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // saturate the reserved count at the frame count
  assign res32 = 32'(reserved_pages);
  assign sat32 = (res32 > 32'(NUM_FRAMES)) ? 32'(NUM_FRAMES) : res32;

  // free decode
  assign fidx    = request.frame_address >> PAGE_SHIFT;
  assign f_range = (fidx >= 32'(NUM_FRAMES));
  assign f_word  = fidx[WIDX_W+5:6];
  assign f_bit   = fidx[5:0];

  // lowest summary row that still has a non-full word
  always_comb begin
    top_free = 1'b0;
    top_row  = '0;
    for (int i = SUM_ROWS - 1; i >= 0; i--) begin
      if (!top_full[i]) begin
        top_free = 1'b1;
        top_row  = RW_AW'(i);
      end
    end
  end

  // init sweep word; padding past the last frame is stored as allocated
  assign full_words = init_count >> 6;
  assign low_mask   = (64'd1 << init_count[5:0]) - 64'd1;
  assign s_last     = (32'(sweep) == 32'(MAP_WORDS - 1));
  assign s_row_wr   = s_last || (sweep[5:0] == 6'd63);

  always_comb begin
    if (32'(sweep) < 32'(full_words)) begin
      s_val = '1;
    end else if (32'(sweep) == 32'(full_words)) begin
      s_val = low_mask;
    end else begin
      s_val = '0;
    end
    if (s_last) begin
      s_val = s_val | LAST_PAD;
    end
    s_acc            = sum_acc;
    s_acc[sweep[5:0]] = &s_val;
    s_row_val        = s_acc;
    if (s_last) begin
      s_row_val = s_acc | ~((64'd2 << sweep[5:0]) - 64'd1);
    end
  end

  // allocate datapath
  assign sb       = pfa_pkg::first_zero64(sum_rdata);
  assign mb       = pfa_pkg::first_zero64(map_rdata);
  assign al_word  = {row, sb};
  assign new_word = map_rdata | (64'd1 << mb);
  assign new_sum  = sum_row | (64'd1 << word_idx[5:0]);
  assign frame    = {word_idx, mb};
  assign grant32  = 32'(frame) << PAGE_SHIFT;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfa_pkg::S_IDLE: begin
        if (start) begin
          case (request.op)
            pfa_pkg::OP_ALLOC: state_next = top_free ? pfa_pkg::S_AL_SUM : pfa_pkg::S_IDLE;
            pfa_pkg::OP_FREE:  state_next = f_range ? pfa_pkg::S_IDLE : pfa_pkg::S_FR_MAP;
            pfa_pkg::OP_INIT:  state_next = pfa_pkg::S_INIT;
            default:           state_next = pfa_pkg::S_IDLE;
          endcase
        end
      end
      pfa_pkg::S_INIT:   state_next = s_last ? pfa_pkg::S_IDLE : pfa_pkg::S_INIT;
      pfa_pkg::S_AL_SUM: state_next = pfa_pkg::S_AL_MAP;
      pfa_pkg::S_AL_MAP: state_next = pfa_pkg::S_IDLE;
      pfa_pkg::S_FR_MAP: state_next = pfa_pkg::S_IDLE;
      default:           state_next = pfa_pkg::S_IDLE;
    endcase
  end

  // outputs: memory controls, summary updates, result
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = word_idx[MW_AW-1:0];
    map_wdata  = new_word;
    map_raddr  = al_word[MW_AW-1:0];
    sum_we     = 1'b0;
    sum_waddr  = row;
    sum_wdata  = new_sum;
    sum_raddr  = top_row;
    top_we     = 1'b0;
    top_idx    = row;
    top_val    = 1'b0;
    fin        = 1'b0;
    fin_result = '0;
    unique case (state)
      pfa_pkg::S_IDLE: begin
        if (request.op == pfa_pkg::OP_FREE) begin
          map_raddr = f_word[MW_AW-1:0];
          sum_raddr = f_word[WIDX_W-1:6];
        end
        if (start) begin
          case (request.op)
            pfa_pkg::OP_ALLOC: begin
              fin                   = !top_free;
              fin_result.status     = pfa_pkg::ST_FULL;
            end
            pfa_pkg::OP_FREE: begin
              fin                   = f_range;
              fin_result.status     = pfa_pkg::ST_RANGE;
            end
            pfa_pkg::OP_INIT: fin   = 1'b0;
            default:          fin   = 1'b1;
          endcase
        end
      end
      pfa_pkg::S_INIT: begin
        map_we    = 1'b1;
        map_waddr = sweep[MW_AW-1:0];
        map_wdata = s_val;
        sum_we    = s_row_wr;
        sum_waddr = sweep[WIDX_W-1:6];
        sum_wdata = s_row_val;
        top_we    = s_row_wr;
        top_idx   = sweep[WIDX_W-1:6];
        top_val   = &s_row_val;
        fin       = s_last && init_report;
      end
      pfa_pkg::S_AL_SUM: begin
        map_raddr = al_word[MW_AW-1:0];
      end
      pfa_pkg::S_AL_MAP: begin
        map_we  = 1'b1;
        sum_we  = &new_word;
        top_we  = &new_word;
        top_val = &new_sum;
        fin     = 1'b1;
        fin_result.granted_address = grant32[pfa_pkg::ADDR_W-1:0];
      end
      pfa_pkg::S_FR_MAP: begin
        map_we    = 1'b1;
        map_wdata = map_rdata & ~(64'd1 << fr_bit);
        sum_we    = 1'b1;
        sum_wdata = sum_rdata & ~(64'd1 << word_idx[5:0]);
        top_we    = 1'b1;
        top_val   = 1'b0;
        fin       = 1'b1;
      end
      default: fin = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pfa_pkg::S_INIT;
      reserved_pages <= pfa_pkg::RESERVED_RESET;
      init_count     <= RST_CNT32[CNT_W-1:0];
      init_report    <= 1'b0;
      sweep          <= '0;
      top_full       <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        reserved_pages <= cfg_data;
      end
      if (accept && request.op == pfa_pkg::OP_INIT) begin
        init_count  <= sat32[CNT_W-1:0];
        init_report <= 1'b1;
        sweep       <= '0;
      end
      if (state == pfa_pkg::S_INIT) begin
        sweep <= sweep + WIDX_W'(1);
      end
      if (top_we) begin
        top_full[top_idx] <= top_val;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    result <= fin_result;
    if (state == pfa_pkg::S_INIT) begin
      sum_acc <= s_acc;
    end
    if (accept && request.op == pfa_pkg::OP_ALLOC) begin
      row <= top_row;
    end
    if (accept && request.op == pfa_pkg::OP_FREE) begin
      row      <= f_word[WIDX_W-1:6];
      word_idx <= f_word;
      fr_bit   <= f_bit;
    end
    if (state == pfa_pkg::S_AL_SUM) begin
      word_idx <= al_word;
      sum_row  <= sum_rdata;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && request.op == pfa_pkg::OP_INIT) |=> busy)
    else $error("initialize did not start the sweep");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != pfa_pkg::ST_OK) |-> (result.granted_address == '0))
    else $error("failed request carries an address");
  a_sum_with_map: assert property (@(posedge clk) disable iff (rst)
    (sum_we && state != pfa_pkg::S_INIT) |-> map_we)
    else $error("summary written without a map write");
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst) $fell(rst) |-> busy)
    else $error("not rebuilding map after reset");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for page_frame_allocator_core: scoreboarded random and directed requests.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF;
  localparam int unsigned FRAME_BYTES = pfa_pkg::FRAME_BYTES_DEF;
  localparam int unsigned MAP_WORDS   = NUM_FRAMES / 64;
  localparam logic [1:0]  OP_SPARE    = 2'd3;       // unused request code
  localparam int unsigned QUIET_LIMIT = 20000;      // longer than the init sweep
  localparam int unsigned PHASE_ITEMS = 147;
  localparam int unsigned NUM_PHASES  = 8;

  // Shadow copy of the allocation bitmap plus the queue of predicted results.
  class frame_map_scoreboard;
    bit [63:0]                 map_words [MAP_WORDS];
    logic [pfa_pkg::RES_W-1:0] reserved_count;
    pfa_pkg::result_t          pending [$];
    int unsigned               mismatches, checked;
    int unsigned               grants, full_hits, frees, range_hits, inits, spares;

    function new();
      reserved_count = pfa_pkg::RESERVED_RESET;
      rebuild_map();
    endfunction

    function void rebuild_map();
      int unsigned count;
      int unsigned lo;
      count = (reserved_count > NUM_FRAMES) ? NUM_FRAMES : reserved_count;
      for (int w = 0; w < MAP_WORDS; w++) begin
        lo = w * 64;
        if (lo + 64 <= count) map_words[w] = '1;
        else if (lo < count) map_words[w] = (64'd1 << (count - lo)) - 64'd1;
        else map_words[w] = '0;
      end
    endfunction

    function bit lowest_free(output int unsigned frame);
      frame = 0;
      for (int w = 0; w < MAP_WORDS; w++) begin
        if (map_words[w] != '1) begin
          for (int b = 0; b < 64; b++) begin
            if (!map_words[w][b]) begin
              frame = w * 64 + b;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Called on each accepted request transfer; returns the predicted result.
    function pfa_pkg::result_t note_request(pfa_pkg::request_t r);
      pfa_pkg::result_t want;
      int unsigned      frame;
      logic [31:0]      byte_addr;
      want.granted_address = '0;
      want.status = pfa_pkg::ST_OK;
      case (r.op)
        pfa_pkg::OP_ALLOC: begin
          if (lowest_free(frame)) begin
            map_words[frame / 64][frame % 64] = 1'b1;
            byte_addr = frame * FRAME_BYTES;
            want.granted_address = byte_addr[pfa_pkg::ADDR_W-1:0];
            grants++;
          end else begin
            want.status = pfa_pkg::ST_FULL;
            full_hits++;
          end
        end
        pfa_pkg::OP_FREE: begin
          frame = r.frame_address / FRAME_BYTES;
          if (frame >= NUM_FRAMES) begin
            want.status = pfa_pkg::ST_RANGE;
            range_hits++;
          end else begin
            map_words[frame / 64][frame % 64] = 1'b0;
            frees++;
          end
        end
        pfa_pkg::OP_INIT: begin
          rebuild_map();
          inits++;
        end
        default: spares++;
      endcase
      pending.push_back(want);
      return want;
    endfunction

    function void check_result(pfa_pkg::result_t got);
      pfa_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t tb: unexpected result, expected none, got addr %h status %0d",
                 $time, got.granted_address, got.status);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.granted_address !== want.granted_address) begin
        $display("%0t tb: granted_address mismatch, expected %h, got %h",
                 $time, want.granted_address, got.granted_address);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t tb: status mismatch, expected %0d, got %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  pfa_pkg::request_t         request = '0;
  logic                      done;
  pfa_pkg::result_t          result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [pfa_pkg::RES_W-1:0] cfg_data = '0;

  frame_map_scoreboard        sb;
  logic [pfa_pkg::ADDR_W-1:0] held [$];      // frames believed allocated by us
  bit                         quiet = 1'b0;  // suppress idle gaps
  int unsigned                cfg_writes = 0;
  int unsigned                quiet_cycles = 0;

  always #1 clk = ~clk;

  page_frame_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t tb: timeout, %0d results outstanding", $time, sb.pending.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic issue(input logic [1:0] op, input logic [31:0] addr);
    pfa_pkg::request_t r;
    pfa_pkg::result_t  want;
    int unsigned       gap;
    r.op = op;
    r.frame_address = addr;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 26) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = sb.note_request(r);
    if (op == pfa_pkg::OP_ALLOC && want.status == pfa_pkg::ST_OK)
      held.push_back(want.granted_address);
    if (op == pfa_pkg::OP_INIT) held.delete();
  endtask

  // drop start and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reserved(input logic [pfa_pkg::RES_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.reserved_count = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned sel;
    int unsigned k;
    logic [31:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 45 || (sel < 80 && held.size() == 0)) begin
      issue(pfa_pkg::OP_ALLOC, $urandom);
    end else if (sel < 80) begin
      // release a frame we hold, with random offset bits inside the page
      k = $urandom_range(0, held.size() - 1);
      a = {2'b00, held[k]} | 32'($urandom_range(0, FRAME_BYTES - 1));
      held.delete(k);
      issue(pfa_pkg::OP_FREE, a);
    end else if (sel < 88) begin
      issue(pfa_pkg::OP_FREE, 32'($urandom_range(0, 32'h3FFF_FFFF)));
    end else if (sel < 94) begin
      issue(pfa_pkg::OP_FREE, {2'($urandom_range(1, 3)), 30'($urandom)});
    end else if (sel < 98) begin
      issue(OP_SPARE, $urandom);
    end else begin
      issue(pfa_pkg::OP_INIT, $urandom);
    end
  endtask

  function automatic logic [pfa_pkg::RES_W-1:0] phase_reserved(input int unsigned p);
    case (p)
      0: return '0;
      1: return pfa_pkg::RESERVED_RESET;
      2: return pfa_pkg::RES_W'(NUM_FRAMES - 40);
      3: return pfa_pkg::RES_W'($urandom_range(0, NUM_FRAMES));
      4: return '1;
      5: return pfa_pkg::RES_W'(NUM_FRAMES);
      6: return pfa_pkg::RES_W'($urandom);
      default: return pfa_pkg::RES_W'(64);
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, starting from the reset reservation
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_FREE, 32'h0084_1FFF);
    issue(pfa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    issue(pfa_pkg::OP_FREE, 32'h0);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_FREE, 32'h3FFF_FFFF);        // top frame, already free
    issue(pfa_pkg::OP_FREE, 32'h4000_0000);        // first address past memory
    issue(pfa_pkg::OP_FREE, 32'hFFFF_FFFF);
    issue(pfa_pkg::OP_FREE, 32'h8000_0000);
    issue(OP_SPARE, 32'hFFFF_FFFF);
    issue(OP_SPARE, 32'h0);
    settle();
    write_reserved(pfa_pkg::RES_W'(NUM_FRAMES - 1)); // one frame left at the top
    issue(pfa_pkg::OP_INIT, 32'h0);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_FREE, 32'h3FFF_F123);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    settle();
    write_reserved('1);                   // saturates at NUM_FRAMES
    issue(pfa_pkg::OP_INIT, 32'hFFFF_FFFF);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_FREE, 32'h1234_5678);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    settle();
    write_reserved('0);
    issue(pfa_pkg::OP_INIT, 32'h0);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_ALLOC, 32'h0);
    issue(pfa_pkg::OP_FREE, 32'h0);
    issue(pfa_pkg::OP_ALLOC, 32'h0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reserved(phase_reserved(p));
      quiet = (p == 3);
      issue(pfa_pkg::OP_INIT, $urandom);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    settle();
    repeat (16) @(posedge clk);
    $display("tb: %0d results checked: %0d grants, %0d full, %0d frees, %0d out of range",
             sb.checked, sb.grants, sb.full_hits, sb.frees, sb.range_hits);
    $display("tb: %0d inits, %0d unused ops, %0d reservation writes, %0d mismatches",
             sb.inits, sb.spares, cfg_writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/page_frame_allocator_core.sv
tb/tb.sv
